FILE: src/ccld_pkg.sv
// shared constants, codes and the stroke merge function for the canvas line drawer
package ccld_pkg;

  // canvas size limits
  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;

  // field widths
  localparam int unsigned CoordW = 6;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned CharW  = 8;

  // register reset values
  localparam logic [SizeW-1:0] RowsReset = 7'd64;
  localparam logic [SizeW-1:0] ColsReset = 7'd64;

  // register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // request kinds
  localparam logic [1:0] REQ_DRAW  = 2'd0;
  localparam logic [1:0] REQ_ERASE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_CROOKED = 2'd2;

  // character codes
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_DASH  = 8'h2D;
  localparam logic [CharW-1:0] CH_BAR   = 8'h7C;
  localparam logic [CharW-1:0] CH_SLASH = 8'h2F;
  localparam logic [CharW-1:0] CH_BSL   = 8'h5C;
  localparam logic [CharW-1:0] CH_BLANK = 8'h2A;

  // combine the old cell with the stroke being drawn
  function automatic logic [CharW-1:0] merge_cell(input logic [CharW-1:0] old_ch,
                                                  input logic [CharW-1:0] sym);
    logic [CharW-1:0] res;
    res = sym;
    if (old_ch == CH_PLUS) begin
      res = CH_PLUS;
    end else if (sym == CH_DASH) begin
      if (old_ch == CH_SLASH || old_ch == CH_BSL || old_ch == CH_BAR) res = CH_PLUS;
    end else if (sym == CH_BAR) begin
      if (old_ch == CH_SLASH || old_ch == CH_BSL || old_ch == CH_DASH) res = CH_PLUS;
    end else if (old_ch == CH_DASH || old_ch == CH_BAR) begin
      res = CH_PLUS;
    end else if (sym == CH_SLASH && old_ch == CH_BSL) begin
      res = CH_PLUS;
    end else if (sym == CH_BSL && old_ch == CH_SLASH) begin
      res = CH_PLUS;
    end
    return res;
  endfunction

endpackage

FILE: src/char_canvas_line_drawer_unit.sv
// character canvas with axis and diagonal line drawing, cell erase and cell read
// flow: a request is checked in ST_CHECK; a draw then reads and writes back each cell
// in ST_RD and ST_WR, erase/read use ST_CELL and ST_CAPT, refused, crooked and unused
// requests go straight to ST_FIN, where a stalled result waits for the output register;
// one item at a time; the single memory port reads a cell in ST_RD, writes it in ST_WR
// reset: canvas cleared to '*' by a pass over all MAX_ROWS*MAX_COLS cells, one cell a
// cycle, no item accepted meanwhile; configuration writes are taken at any time
module char_canvas_line_drawer_unit #(
  parameter int unsigned MAX_ROWS = ccld_pkg::MaxRows,
  parameter int unsigned MAX_COLS = ccld_pkg::MaxCols
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  // request items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // first_row, first_col, last_row, last_col
  input  logic [1:0]  s_axis_tuser,  // req_type
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // cell_value
  output logic [1:0]  m_axis_tuser   // status
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = ccld_pkg::CoordW;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_RD, ST_WR, ST_CELL, ST_CAPT, ST_FIN
  } state_e;

  state_e state_q;

  logic [ccld_pkg::SizeW-1:0] rows_q, cols_q;
  logic [AddrW-1:0]           clr_q;
  logic [1:0]                 type_q;
  logic [CW-1:0]              r0_q, c0_q, r1_q, c1_q;
  logic [CW-1:0]              cur_r_q, cur_c_q, cnt_q;
  logic                       inc_r_q, dec_r_q, inc_c_q, dec_c_q;
  logic [ccld_pkg::CharW-1:0] sym_q, val_q;
  logic [1:0]                 stat_q;
  logic                       out_valid_q;
  logic [1:0]                 out_stat_q;
  logic [ccld_pkg::CharW-1:0] out_val_q;

  logic [ccld_pkg::CharW-1:0] mem_q [Depth];
  logic [ccld_pkg::CharW-1:0] mem_rd_q;
  logic                       mem_we;
  logic [AddrW-1:0]           mem_addr, cell_addr;
  logic [ccld_pkg::CharW-1:0] mem_wdata;

  // range and shape checks on the held request
  logic          ok0, ok1, ok_rows0, ok_rows1, ok_cols0, ok_cols1;
  logic [CW-1:0] dr, dc;

  assign ok_rows0 = ({1'b0, r0_q} < rows_q) && (32'(r0_q) < MAX_ROWS);
  assign ok_rows1 = ({1'b0, r1_q} < rows_q) && (32'(r1_q) < MAX_ROWS);
  assign ok_cols0 = ({1'b0, c0_q} < cols_q) && (32'(c0_q) < MAX_COLS);
  assign ok_cols1 = ({1'b0, c1_q} < cols_q) && (32'(c1_q) < MAX_COLS);
  assign ok0 = ok_rows0 && ok_cols0;
  assign ok1 = ok_rows1 && ok_cols1;
  assign dr  = (r1_q >= r0_q) ? (r1_q - r0_q) : (r0_q - r1_q);
  assign dc  = (c1_q >= c0_q) ? (c1_q - c0_q) : (c0_q - c1_q);

  // cell address and memory port controls
  assign cell_addr = AddrW'(32'(cur_r_q) * MAX_COLS + 32'(cur_c_q));

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cell_addr;
    mem_wdata = ccld_pkg::merge_cell(mem_rd_q, sym_q);
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = ccld_pkg::CH_BLANK;
      end
      ST_WR: mem_we = 1'b1;
      ST_CELL: begin
        mem_we    = (type_q == ccld_pkg::REQ_ERASE);
        mem_wdata = ccld_pkg::CH_BLANK;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // single-port canvas memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else begin
      mem_rd_q <= mem_q[mem_addr];
    end
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ccld_pkg::RowsReset;
      cols_q <= ccld_pkg::ColsReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ccld_pkg::REG_ROWS: rows_q <= cfg_data_i;
        ccld_pkg::REG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(Depth - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            type_q  <= s_axis_tuser;
            r0_q    <= s_axis_tdata[5:0];
            c0_q    <= s_axis_tdata[11:6];
            r1_q    <= s_axis_tdata[17:12];
            c1_q    <= s_axis_tdata[23:18];
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          stat_q  <= ccld_pkg::STAT_OK;
          val_q   <= '0;
          cur_r_q <= r0_q;
          cur_c_q <= c0_q;
          inc_r_q <= (r1_q > r0_q);
          dec_r_q <= (r1_q < r0_q);
          inc_c_q <= (c1_q > c0_q);
          dec_c_q <= (c1_q < c0_q);
          state_q <= ST_FIN;
          if (type_q == ccld_pkg::REQ_DRAW) begin
            if (!ok0 || !ok1) begin
              stat_q <= ccld_pkg::STAT_RANGE;
            end else if (dr == '0) begin
              sym_q   <= ccld_pkg::CH_DASH;
              cnt_q   <= dc;
              state_q <= ST_RD;
            end else if (dc == '0) begin
              sym_q   <= ccld_pkg::CH_BAR;
              cnt_q   <= dr;
              state_q <= ST_RD;
            end else if (dr == dc) begin
              sym_q   <= ((r0_q < r1_q) == (c0_q < c1_q)) ? ccld_pkg::CH_SLASH
                                                          : ccld_pkg::CH_BSL;
              cnt_q   <= dr;
              state_q <= ST_RD;
            end else begin
              stat_q <= ccld_pkg::STAT_CROOKED;
            end
          end else if (type_q == ccld_pkg::REQ_ERASE || type_q == ccld_pkg::REQ_READ) begin
            if (!ok0) stat_q <= ccld_pkg::STAT_RANGE;
            else      state_q <= ST_CELL;
          end
        end
        ST_RD: state_q <= ST_WR;
        ST_WR: begin
          cur_r_q <= cur_r_q + CW'(inc_r_q) - CW'(dec_r_q);
          cur_c_q <= cur_c_q + CW'(inc_c_q) - CW'(dec_c_q);
          cnt_q   <= cnt_q - 1'b1;
          state_q <= (cnt_q == '0) ? ST_FIN : ST_RD;
        end
        ST_CELL: state_q <= ST_CAPT;
        ST_CAPT: begin
          if (type_q == ccld_pkg::REQ_READ) val_q <= mem_rd_q;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_stat_q  <= stat_q;
            out_val_q   <= val_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_stat_q;

  // a failed request never reports a cell value
  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ccld_pkg::STAT_OK |-> m_axis_tdata == '0)
    else $error("failed request carries a cell value");

  // the canvas is never written while waiting for a request
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !mem_we)
    else $error("memory write while idle");

  // every write-back of a line lands inside the canvas
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WR |-> 32'(cur_r_q) < MAX_ROWS && 32'(cur_c_q) < MAX_COLS)
    else $error("line write outside the canvas");

  // each written cell moves on to the next read with one cell fewer to go
  a_cell_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WR && cnt_q != '0 |=> state_q == ST_RD && cnt_q == $past(cnt_q) - 1'b1)
    else $error("line cell count out of step");

endmodule
